>>> rtl/csp_pkg.sv
`default_nettype none

package csp_pkg;

	// field widths
	localparam int VAL_W   = 32;
	localparam int T_W     = 17;
	localparam int NUM_PTS = 4;

	// packed stream widths
	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 32;

	// t equal to one in Q1.16
	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	// weight format: Q2.30 held in 32 bits
	localparam int WGT_W    = 32;
	localparam int WGT_FRAC = 30;

	// raw weight width at scale 2^48 plus margin for the catmull-rom sum
	localparam int RAW_W = 54;

	// rounding shifts from scale 2^48 (hermite) and 2^49 (catmull-rom)
	localparam int HERM_SHIFT = 48 - WGT_FRAC;
	localparam int CATR_SHIFT = 49 - WGT_FRAC;

	localparam logic signed [RAW_W-1:0] RAW_ONE  = 54'sd1 <<< 48;
	localparam logic signed [RAW_W-1:0] HERM_HALF = 54'sd1 <<< (HERM_SHIFT - 1);
	localparam logic signed [RAW_W-1:0] CATR_HALF = 54'sd1 <<< (CATR_SHIFT - 1);

	// accumulator widths
	localparam int PROD_W = 64;
	localparam int PAIR_W = 65;
	localparam int SUM_W  = 66;
	localparam int RND_W  = SUM_W - WGT_FRAC;

	localparam logic signed [SUM_W-1:0] SUM_HALF = 66'sd1 <<< (WGT_FRAC - 1);

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum logic {
		MODE_HERMITE = 1'b0,
		MODE_CATMULL = 1'b1
	} mode_t;

	typedef logic [NUM_PTS-1:0][VAL_W-1:0] quad_t;

	// word handed from the weight pipe to the multiply-accumulate pipe
	typedef struct packed {
		quad_t wgt;
		quad_t vals;
	} wt_word_t;

endpackage

`default_nettype wire

>>> rtl/cubic_spline_point_eval.sv
// an accepted word passes stages s1 to s4 (csp_basis), then s5 to s8 (csp_mac)
// throughput: one word per cycle; each stage holds while its successor is full,
// so an output stall pauses flow, bubbles close up, nothing dropped or repeated
// the rate is set by the eight-stage pipe: powers, weights, products, adder tree
// reset: arst_n clears every stage valid flag; payload registers are not reset
`default_nettype none

module cubic_spline_point_eval (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// p0 [31:0], p1 [63:32], p2 [95:64], p3 [127:96], param_t [144:128], zero pad
	input  wire logic [151:0] s_axis_tdata,
	// action [0]
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// value [31:0]
	output logic [31:0]       m_axis_tdata,
	// saturated [0]
	output logic [0:0]        m_axis_tuser
);

	csp_pkg::quad_t    in_vals;
	csp_pkg::wt_word_t mid_word;
	logic              mid_valid;
	logic              mid_ready;

	// unpack control values
	always_comb begin
		for (int i = 0; i < csp_pkg::NUM_PTS; i++) begin
			in_vals[i] = s_axis_tdata[i*csp_pkg::VAL_W +: csp_pkg::VAL_W];
		end
	end

	// t powers and basis weights
	csp_basis u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (csp_pkg::mode_t'(s_axis_tuser[0])),
		.in_vals   (in_vals),
		.in_t      (s_axis_tdata[144:128]),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_word  (mid_word)
	);

	// weighted sum, rounding and clipping
	csp_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_word   (mid_word),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_sat   (m_axis_tuser[0])
	);

endmodule

`default_nettype wire

>>> rtl/csp_basis.sv
`default_nettype none

module csp_basis (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire csp_pkg::mode_t     in_mode,
	input  wire csp_pkg::quad_t     in_vals,
	input  wire logic [csp_pkg::T_W-1:0] in_t,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output csp_pkg::wt_word_t       out_word
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	csp_pkg::mode_t mode_s1, mode_s2, mode_s3;
	csp_pkg::quad_t vals_s1, vals_s2, vals_s3;
	logic [csp_pkg::T_W-1:0] tc_s1, tc_s2, tc_s3;
	logic [32:0] t2_s2, t2_s3;
	logic [48:0] t3_s3;
	csp_pkg::wt_word_t word_s4;

	logic [csp_pkg::T_W-1:0] t_clamp;
	logic [33:0] t2_full;
	logic [49:0] t3_full;

	logic signed [csp_pkg::RAW_W-1:0] a, b, c;
	logic signed [csp_pkg::RAW_W-1:0] h0, h1, h2, h3;
	logic signed [csp_pkg::RAW_W-1:0] r0, r1, r2, r3;
	logic signed [csp_pkg::RAW_W-1:0] sh0, sh1, sh2, sh3;
	csp_pkg::quad_t wgt;

	// stage ready chain, bubbles are filled while the output stalls
	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// t beyond one is held at one
	assign t_clamp = (in_t > csp_pkg::T_ONE) ? csp_pkg::T_ONE : in_t;

	// t squared and t cubed
	assign t2_full = tc_s1 * tc_s1;
	assign t3_full = t2_s2 * tc_s2;

	// powers at scale 2^48
	assign a = $signed({5'b0, t3_s3});
	assign b = $signed({5'b0, t2_s3, 16'b0});
	assign c = $signed({5'b0, tc_s3, 32'b0});

	// raw weights with half an lsb folded in, per basis
	always_comb begin
		if (mode_s3 == csp_pkg::MODE_HERMITE) begin
			h0 = 2*a - 3*b + csp_pkg::RAW_ONE + csp_pkg::HERM_HALF;
			h1 = a - 2*b + c + csp_pkg::HERM_HALF;
			h2 = 3*b - 2*a + csp_pkg::HERM_HALF;
			h3 = a - b + csp_pkg::HERM_HALF;
		end else begin
			h0 = 2*b - a - c + csp_pkg::CATR_HALF;
			h1 = 3*a - 5*b + 2*csp_pkg::RAW_ONE + csp_pkg::CATR_HALF;
			h2 = 4*b - 3*a + c + csp_pkg::CATR_HALF;
			h3 = a - b + csp_pkg::CATR_HALF;
		end
		r0 = h0;
		r1 = h1;
		r2 = h2;
		r3 = h3;
	end

	// floor to q2.30
	always_comb begin
		if (mode_s3 == csp_pkg::MODE_HERMITE) begin
			sh0 = r0 >>> csp_pkg::HERM_SHIFT;
			sh1 = r1 >>> csp_pkg::HERM_SHIFT;
			sh2 = r2 >>> csp_pkg::HERM_SHIFT;
			sh3 = r3 >>> csp_pkg::HERM_SHIFT;
		end else begin
			sh0 = r0 >>> csp_pkg::CATR_SHIFT;
			sh1 = r1 >>> csp_pkg::CATR_SHIFT;
			sh2 = r2 >>> csp_pkg::CATR_SHIFT;
			sh3 = r3 >>> csp_pkg::CATR_SHIFT;
		end
		wgt[0] = sh0[csp_pkg::WGT_W-1:0];
		wgt[1] = sh1[csp_pkg::WGT_W-1:0];
		wgt[2] = sh2[csp_pkg::WGT_W-1:0];
		wgt[3] = sh3[csp_pkg::WGT_W-1:0];
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mode_s1 <= in_mode;
			vals_s1 <= in_vals;
			tc_s1   <= t_clamp;
		end
		if (rdy_s2 && vld_s1) begin
			mode_s2 <= mode_s1;
			vals_s2 <= vals_s1;
			tc_s2   <= tc_s1;
			t2_s2   <= t2_full[32:0];
		end
		if (rdy_s3 && vld_s2) begin
			mode_s3 <= mode_s2;
			vals_s3 <= vals_s2;
			tc_s3   <= tc_s2;
			t2_s3   <= t2_s2;
			t3_s3   <= t3_full[48:0];
		end
		if (rdy_s4 && vld_s3) begin
			word_s4.wgt  <= wgt;
			word_s4.vals <= vals_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_word  = word_s4;

endmodule

`default_nettype wire

>>> rtl/csp_mac.sv
`default_nettype none

module csp_mac (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire csp_pkg::wt_word_t       in_word,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [csp_pkg::VAL_W-1:0]    out_value,
	output logic                         out_sat
);

	logic vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	logic signed [csp_pkg::PROD_W-1:0] prod_s5 [csp_pkg::NUM_PTS];
	logic signed [csp_pkg::PROD_W-1:0] prod [csp_pkg::NUM_PTS];
	logic signed [csp_pkg::PAIR_W-1:0] pair_s6 [2];
	logic signed [csp_pkg::SUM_W-1:0]  tot_s7;
	logic [csp_pkg::VAL_W-1:0]         value_s8;
	logic                              sat_s8;

	logic signed [csp_pkg::PAIR_W-1:0] pair [2];
	logic signed [csp_pkg::SUM_W-1:0]  tot;
	logic signed [csp_pkg::RND_W-1:0]  rnd;
	logic                              clip;
	logic [csp_pkg::VAL_W-1:0]         clip_val;

	// stage ready chain
	assign rdy_s8   = !vld_s8 || out_ready;
	assign rdy_s7   = !vld_s7 || rdy_s8;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	// one 32 by 32 product per lane
	always_comb begin
		for (int i = 0; i < csp_pkg::NUM_PTS; i++) begin
			prod[i] = $signed(in_word.wgt[i]) * $signed(in_word.vals[i]);
		end
	end

	// pairwise sums
	assign pair[0] = csp_pkg::PAIR_W'(prod_s5[0]) + csp_pkg::PAIR_W'(prod_s5[1]);
	assign pair[1] = csp_pkg::PAIR_W'(prod_s5[2]) + csp_pkg::PAIR_W'(prod_s5[3]);

	// final sum with the rounding half added
	assign tot = csp_pkg::SUM_W'(pair_s6[0]) + csp_pkg::SUM_W'(pair_s6[1])
		+ csp_pkg::SUM_HALF;

	// drop weight fraction and clip to the value range
	assign rnd  = tot_s7[csp_pkg::SUM_W-1:csp_pkg::WGT_FRAC];
	assign clip = !((&rnd[csp_pkg::RND_W-1:csp_pkg::VAL_W-1])
		|| !(|rnd[csp_pkg::RND_W-1:csp_pkg::VAL_W-1]));

	always_comb begin
		if (!clip) begin
			clip_val = rnd[csp_pkg::VAL_W-1:0];
		end else if (rnd[csp_pkg::RND_W-1]) begin
			clip_val = csp_pkg::VAL_MIN;
		end else begin
			clip_val = csp_pkg::VAL_MAX;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s5) vld_s5 <= in_valid;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			for (int i = 0; i < csp_pkg::NUM_PTS; i++) begin
				prod_s5[i] <= prod[i];
			end
		end
		if (rdy_s6 && vld_s5) begin
			pair_s6[0] <= pair[0];
			pair_s6[1] <= pair[1];
		end
		if (rdy_s7 && vld_s6) begin
			tot_s7 <= tot;
		end
		if (rdy_s8 && vld_s7) begin
			value_s8 <= clip_val;
			sat_s8   <= clip;
		end
	end

	assign out_valid = vld_s8;
	assign out_value = value_s8;
	assign out_sat   = sat_s8;

endmodule

`default_nettype wire
